>>> hdl/ac_peak_period_phase_meter_defines.svh
// assertion macros used by the meter's top-level rtl file
`ifndef AC_PEAK_PERIOD_PHASE_METER_DEFINES_SVH
`define AC_PEAK_PERIOD_PHASE_METER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ACPM_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
`define ACPM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ACPM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ACPM_ASSERT(name, cond)
`define ACPM_ASSERT_IMPL(name, ante, cons)
`define ACPM_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> hdl/acpm_pkg.sv
// types and constants of the ac peak, period and phase meter
package acpm_pkg;

  localparam int unsigned SAMPLE_BITS = 14;
  localparam int unsigned QUOT_BITS   = 14;
  localparam int unsigned MUL_B_BITS  = 16;
  localparam int unsigned PHASE_BITS  = 12;

  localparam logic [MUL_B_BITS-1:0] RMS_FACTOR = 16'd46341;
  localparam logic [MUL_B_BITS-1:0] FULL_TURN  = 16'd3600;

  localparam logic [QUOT_BITS-2:0] QUOT_FULL_TURN = 13'd3600;
  localparam logic [QUOT_BITS-2:0] QUOT_HALF_TURN = 13'd1800;
  localparam logic [QUOT_BITS-2:0] QUOT_WRAP_MAX  = 13'd5400;

  localparam logic signed [PHASE_BITS-1:0] PHASE_MAX = 12'sd1800;
  localparam logic signed [PHASE_BITS-1:0] PHASE_MIN = -12'sd1800;

  localparam logic [SAMPLE_BITS-1:0] CH1_THR_RESET = 14'd248;
  localparam logic [SAMPLE_BITS-1:0] CH2_THR_RESET = 14'd99;

  // register index, taken from paddr bit 2
  localparam logic REG_CH1_THR = 1'b0;
  localparam logic REG_CH2_THR = 1'b1;

  typedef enum logic [5:0] {
    ST_SYNC    = 6'b000001,
    ST_RISE1   = 6'b000010,
    ST_HUMP1   = 6'b000100,
    ST_VALLEY1 = 6'b001000,
    ST_RISE2   = 6'b010000,
    ST_HUMP2   = 6'b100000
  } stage_e;

  typedef enum logic [6:0] {
    AR_IDLE = 7'b0000001,
    AR_MULD = 7'b0000010,
    AR_INIT = 7'b0000100,
    AR_DIV  = 7'b0001000,
    AR_MUL1 = 7'b0010000,
    AR_MUL2 = 7'b0100000,
    AR_FIN  = 7'b1000000
  } arith_e;

  typedef struct packed {
    logic start;
    logic load;
  } arith_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak_one;
    logic [SAMPLE_BITS-1:0] peak_two;
  } peaks_t;

endpackage

>>> hdl/ac_peak_period_phase_meter.sv
// top level of the ac peak, period and phase meter
//
// input channel: one beat per sample tick with both 14-bit adc codes
// (in_valid_i / in_stall_o). output channel: one beat per completed
// measurement with period, peaks, rms values and phase (out_valid_o /
// out_stall_i). the user must write thresholds over the apb port only
// while idle; the block itself does not enforce this. an ordinary tick
// is taken while the sequencer is idle, so in_stall_o stays low. the
// tick that ends the channel two hump starts the arithmetic sequencer:
// one shared multiply for delay*3600, a setup state, 14
// compare/subtract steps for the phase quotient, two shared multiplies
// for the rms values and a result state, with in_stall_o high
// throughout. if the receiver stalls, the result stays in the output
// register and the sequencer holds; input stays stalled until the
// result moves. reset clears the sequence to waiting for both valleys,
// restores default thresholds and drops out_valid_o.
`include "ac_peak_period_phase_meter_defines.svh"

module ac_peak_period_phase_meter #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [acpm_pkg::SAMPLE_BITS-1:0]       ch1_sample_i,
  input  logic [acpm_pkg::SAMPLE_BITS-1:0]       ch2_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [COUNT_WIDTH:0]                   period_ticks_o,
  output logic [acpm_pkg::SAMPLE_BITS-1:0]       ch1_peak_o,
  output logic [acpm_pkg::SAMPLE_BITS-1:0]       ch2_peak_o,
  output logic [acpm_pkg::SAMPLE_BITS-1:0]       ch1_rms_o,
  output logic [acpm_pkg::SAMPLE_BITS-1:0]       ch2_rms_o,
  output logic signed [acpm_pkg::PHASE_BITS-1:0] phase_tenths_o,
  output logic                                   phase_out_of_range_o
);

  logic [acpm_pkg::SAMPLE_BITS-1:0] ch1_thr_q, ch2_thr_q;
  logic cfg_wr, in_accept;
  logic arith_start, arith_load;
  acpm_pkg::arith_ctrl_t ctrl;
  acpm_pkg::arith_stat_t stat;
  acpm_pkg::peaks_t peaks;
  logic [COUNT_WIDTH-1:0] valley, delay;
  logic [acpm_pkg::SAMPLE_BITS-1:0] rms1, rms2;
  logic signed [acpm_pkg::PHASE_BITS-1:0] phase;
  logic flag;
  logic out_valid_q;
  logic [COUNT_WIDTH:0] period_q;
  acpm_pkg::peaks_t peaks_q;
  logic [acpm_pkg::SAMPLE_BITS-1:0] rms1_q, rms2_q;
  logic signed [acpm_pkg::PHASE_BITS-1:0] phase_q;
  logic flag_q;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch1_thr_q <= acpm_pkg::CH1_THR_RESET;
      ch2_thr_q <= acpm_pkg::CH2_THR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == acpm_pkg::REG_CH1_THR) begin
        ch1_thr_q <= pwdata[acpm_pkg::SAMPLE_BITS-1:0];
      end else begin
        ch2_thr_q <= pwdata[acpm_pkg::SAMPLE_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == acpm_pkg::REG_CH1_THR) ? 32'(ch1_thr_q) : 32'(ch2_thr_q);

  assign in_stall_o = stat.busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  acpm_track #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .ch1_sample_i(ch1_sample_i),
    .ch2_sample_i(ch2_sample_i),
    .ch1_thr_i   (ch1_thr_q),
    .ch2_thr_i   (ch2_thr_q),
    .start_o     (arith_start),
    .peaks_o     (peaks),
    .valley_o    (valley),
    .delay_o     (delay)
  );

  assign arith_load = stat.done && (!out_valid_q || !out_stall_i);
  assign ctrl       = '{start: arith_start, load: arith_load};

  acpm_arith #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .peaks_i  (peaks),
    .valley_i (valley),
    .delay_i  (delay),
    .ch1_rms_o(rms1),
    .ch2_rms_o(rms2),
    .phase_o  (phase),
    .flag_o   (flag)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (arith_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (arith_load) begin
      period_q <= {valley, 1'b0};
      peaks_q  <= peaks;
      rms1_q   <= rms1;
      rms2_q   <= rms2;
      phase_q  <= phase;
      flag_q   <= flag;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign period_ticks_o       = period_q;
  assign ch1_peak_o           = peaks_q.peak_one;
  assign ch2_peak_o           = peaks_q.peak_two;
  assign ch1_rms_o            = rms1_q;
  assign ch2_rms_o            = rms2_q;
  assign phase_tenths_o       = phase_q;
  assign phase_out_of_range_o = flag_q;

  `ACPM_ASSERT_IMPL(a_phase_range, out_valid_o,
    phase_tenths_o <= acpm_pkg::PHASE_MAX && phase_tenths_o >= acpm_pkg::PHASE_MIN)
  `ACPM_ASSERT_IMPL(a_flag_clamps, out_valid_o && phase_out_of_range_o,
    phase_tenths_o == acpm_pkg::PHASE_MAX)
  `ACPM_ASSERT_IMPL(a_rms_below_peak, out_valid_o,
    ch1_rms_o <= ch1_peak_o && ch2_rms_o <= ch2_peak_o)
  `ACPM_ASSERT_NEXT(a_start_stalls, arith_start, in_stall_o)
  `ACPM_ASSERT_IMPL(a_period_even, out_valid_o, !period_ticks_o[0] && period_ticks_o != '0)

endmodule

>>> hdl/acpm_track.sv
// per-tick sequence tracker: stage, peaks, valley and delay counters
module acpm_track #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [acpm_pkg::SAMPLE_BITS-1:0]    ch1_sample_i,
  input  logic [acpm_pkg::SAMPLE_BITS-1:0]    ch2_sample_i,
  input  logic [acpm_pkg::SAMPLE_BITS-1:0]    ch1_thr_i,
  input  logic [acpm_pkg::SAMPLE_BITS-1:0]    ch2_thr_i,
  output logic                                start_o,
  output acpm_pkg::peaks_t                    peaks_o,
  output logic [COUNT_WIDTH-1:0]              valley_o,
  output logic [COUNT_WIDTH-1:0]              delay_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  acpm_pkg::stage_e stage_q, stage_d;
  acpm_pkg::peaks_t peaks_q, peaks_d;
  logic [COUNT_WIDTH-1:0] valley_q, valley_d;
  logic [COUNT_WIDTH-1:0] delay_q, delay_d;
  logic up1, up2;

  assign up1 = ch1_sample_i > ch1_thr_i;
  assign up2 = ch2_sample_i > ch2_thr_i;

  always_comb begin
    stage_d  = stage_q;
    peaks_d  = peaks_q;
    valley_d = valley_q;
    delay_d  = delay_q;
    start_o  = 1'b0;
    if (accept_i) begin
      unique case (stage_q)
        acpm_pkg::ST_RISE1: begin
          if (up1) begin
            peaks_d.peak_one = ch1_sample_i;
            stage_d          = acpm_pkg::ST_HUMP1;
          end
        end
        acpm_pkg::ST_HUMP1: begin
          if (up1) begin
            if (ch1_sample_i > peaks_q.peak_one) begin
              peaks_d.peak_one = ch1_sample_i;
            end
          end else begin
            valley_d = COUNT_WIDTH'(1);
            stage_d  = acpm_pkg::ST_VALLEY1;
          end
        end
        acpm_pkg::ST_VALLEY1: begin
          if (!up1) begin
            valley_d = (valley_q == CountMax) ? valley_q : valley_q + 1'b1;
          end else begin
            delay_d = '0;
            if (up2) begin
              peaks_d.peak_two = ch2_sample_i;
              stage_d          = acpm_pkg::ST_HUMP2;
            end else begin
              stage_d = acpm_pkg::ST_RISE2;
            end
          end
        end
        acpm_pkg::ST_RISE2: begin
          delay_d = (delay_q == CountMax) ? delay_q : delay_q + 1'b1;
          if (up2) begin
            peaks_d.peak_two = ch2_sample_i;
            stage_d          = acpm_pkg::ST_HUMP2;
          end
        end
        acpm_pkg::ST_HUMP2: begin
          if (up2) begin
            if (ch2_sample_i > peaks_q.peak_two) begin
              peaks_d.peak_two = ch2_sample_i;
            end
          end else begin
            start_o = 1'b1;
            stage_d = acpm_pkg::ST_SYNC;
          end
        end
        default: begin
          if (!up1 && !up2) begin
            peaks_d = '0;
            stage_d = acpm_pkg::ST_RISE1;
          end else begin
            stage_d = acpm_pkg::ST_SYNC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= acpm_pkg::ST_SYNC;
      peaks_q  <= '0;
      valley_q <= '0;
      delay_q  <= '0;
    end else begin
      stage_q  <= stage_d;
      peaks_q  <= peaks_d;
      valley_q <= valley_d;
      delay_q  <= delay_d;
    end
  end

  assign peaks_o  = peaks_q;
  assign valley_o = valley_q;
  assign delay_o  = delay_q;

endmodule

>>> hdl/acpm_arith.sv
// shared multiplier and compare/subtract unit for phase and rms
module acpm_arith #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  acpm_pkg::arith_ctrl_t                 ctrl_i,
  output acpm_pkg::arith_stat_t                 stat_o,
  input  acpm_pkg::peaks_t                      peaks_i,
  input  logic [COUNT_WIDTH-1:0]                valley_i,
  input  logic [COUNT_WIDTH-1:0]                delay_i,
  output logic [acpm_pkg::SAMPLE_BITS-1:0]      ch1_rms_o,
  output logic [acpm_pkg::SAMPLE_BITS-1:0]      ch2_rms_o,
  output logic signed [acpm_pkg::PHASE_BITS-1:0] phase_o,
  output logic                                  flag_o
);

  localparam int unsigned PW = COUNT_WIDTH + acpm_pkg::MUL_B_BITS;
  localparam int unsigned RW = COUNT_WIDTH + acpm_pkg::QUOT_BITS;
  localparam int unsigned CW = $clog2(acpm_pkg::QUOT_BITS);
  localparam int unsigned RMS_LSB = acpm_pkg::MUL_B_BITS;
  localparam int unsigned RMS_MSB = RMS_LSB + acpm_pkg::SAMPLE_BITS - 1;
  localparam int unsigned NUM_MSB = COUNT_WIDTH + 11;

  acpm_pkg::arith_e state_q, state_d;
  logic [PW-1:0] prod_q;
  logic [RW-1:0] rem_q, dsh_q;
  logic [acpm_pkg::QUOT_BITS-1:0] quot_q;
  logic [CW-1:0] cnt_q;
  logic [acpm_pkg::SAMPLE_BITS-1:0] rms1_q;
  logic [COUNT_WIDTH-1:0] mul_a;
  logic [acpm_pkg::MUL_B_BITS-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic [RW:0] diff;
  logic ge;
  logic [acpm_pkg::QUOT_BITS-2:0] q;
  logic [acpm_pkg::QUOT_BITS-2:0] q_wrap;

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      acpm_pkg::AR_MUL1: begin
        mul_a = COUNT_WIDTH'(peaks_i.peak_one);
        mul_b = acpm_pkg::RMS_FACTOR;
      end
      acpm_pkg::AR_MUL2: begin
        mul_a = COUNT_WIDTH'(peaks_i.peak_two);
        mul_b = acpm_pkg::RMS_FACTOR;
      end
      default: begin
        mul_a = delay_i;
        mul_b = acpm_pkg::FULL_TURN;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // shared compare/subtract, one quotient bit a step
  assign diff = {1'b0, rem_q} - {1'b0, dsh_q};
  assign ge   = !diff[RW];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acpm_pkg::AR_IDLE: if (ctrl_i.start) state_d = acpm_pkg::AR_MULD;
      acpm_pkg::AR_MULD: state_d = acpm_pkg::AR_INIT;
      acpm_pkg::AR_INIT: state_d = acpm_pkg::AR_DIV;
      acpm_pkg::AR_DIV:  if (cnt_q == '0) state_d = acpm_pkg::AR_MUL1;
      acpm_pkg::AR_MUL1: state_d = acpm_pkg::AR_MUL2;
      acpm_pkg::AR_MUL2: state_d = acpm_pkg::AR_FIN;
      acpm_pkg::AR_FIN:  if (ctrl_i.load) state_d = acpm_pkg::AR_IDLE;
      default:           state_d = acpm_pkg::AR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acpm_pkg::AR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == acpm_pkg::AR_INIT) begin
        cnt_q <= CW'(acpm_pkg::QUOT_BITS - 1);
      end else if (state_q == acpm_pkg::AR_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == acpm_pkg::AR_MULD || state_q == acpm_pkg::AR_MUL1 ||
        state_q == acpm_pkg::AR_MUL2) begin
      prod_q <= mul_p;
    end
    if (state_q == acpm_pkg::AR_INIT) begin
      // numerator delay*3600 + period/2, divisor period aligned to the top quotient bit
      rem_q  <= RW'(prod_q[NUM_MSB:0]) + RW'(valley_i);
      dsh_q  <= {valley_i, 1'b0, {(acpm_pkg::QUOT_BITS - 1){1'b0}}};
      quot_q <= '0;
    end else if (state_q == acpm_pkg::AR_DIV) begin
      if (ge) begin
        rem_q <= diff[RW-1:0];
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[acpm_pkg::QUOT_BITS-2:0], ge};
    end
    if (state_q == acpm_pkg::AR_MUL2) begin
      rms1_q <= prod_q[RMS_MSB:RMS_LSB];
    end
  end

  assign q      = quot_q[acpm_pkg::QUOT_BITS-2:0];
  assign q_wrap = q - acpm_pkg::QUOT_FULL_TURN;

  always_comb begin
    flag_o = 1'b0;
    if (quot_q[acpm_pkg::QUOT_BITS-1] || q > acpm_pkg::QUOT_WRAP_MAX) begin
      phase_o = acpm_pkg::PHASE_MAX;
      flag_o  = 1'b1;
    end else if (q > acpm_pkg::QUOT_HALF_TURN) begin
      phase_o = q_wrap[acpm_pkg::PHASE_BITS-1:0];
    end else begin
      phase_o = q[acpm_pkg::PHASE_BITS-1:0];
    end
  end

  assign ch1_rms_o = rms1_q;
  assign ch2_rms_o = prod_q[RMS_MSB:RMS_LSB];
  assign stat_o    = '{busy: (state_q != acpm_pkg::AR_IDLE),
                       done: (state_q == acpm_pkg::AR_FIN)};

endmodule
